FILE: hw/rtl/csl_pkg.sv
// Shared types and constants of the compressed image sector locator.
package csl_pkg;

   localparam int INDEX_DEPTH_DEF = 4096;
   localparam int MAX_BURST_DEF   = 64;
   localparam int SECTOR_SHIFT    = 11;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_SPB         = 32;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ZSO_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SECTORS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_PER_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_SHIFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_SIZE     = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_DIV, S_CHECK, S_RD, S_SHIFT, S_EVAL, S_CLAMP, S_EMIT
   } csl_state_type;

   typedef enum logic [2:0] {
      RES_RANGE, RES_ISO, RES_HIT, RES_BEYOND, RES_CORRUPT, RES_LOAD
   } csl_res_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0, STAT_RANGE = 2'd1, STAT_BEYOND = 2'd2, STAT_CORRUPT = 2'd3
   } csl_status_type;

   typedef struct packed {
      logic        write;
      logic        take;
      logic        div_start;
      logic        div_step;
      logic        rd_lo;
      logic        rd_hi;
      logic        shift;
      logic        eval;
      logic        out_load;
      csl_res_type kind;
      logic        sec_next;
   } csl_cmd_type;

   typedef struct packed {
      logic range_bad;
      logic zso;
      logic div_done;
      logic hit;
      logic beyond;
      logic corrupt;
      logic last;
   } csl_stat_type;

endpackage

FILE: hw/rtl/compressed_image_sector_locator.sv
// Top level of the compressed image sector locator.
// Index-write items are taken while the controller is idle and leave it
// idle. A read request that fails the range check, or any read in plain ISO
// mode, gives its single item: the request passes S_DECIDE and the item is
// then offered from S_EMIT. In compressed mode the first sector's block and
// slot come from a one-bit-per-cycle divider; each sector then passes S_CHECK
// and S_EMIT when its block is current, and S_CHECK, S_RD, S_SHIFT, S_EVAL,
// S_CLAMP and S_EMIT when the two index words must be fetched through the
// single read port of the index memory, and waits in S_EMIT while rsp_stall
// is high. One request is worked at a time; req_stall is high until its last
// item is taken. The index memory has no reset and no clearing pass.
module compressed_image_sector_locator import csl_pkg::*; #(
   parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
   parameter int MAX_BURST   = MAX_BURST_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [22:0]           req_lba,
   input  logic [6:0]            req_count,
   input  logic [11:0]           req_entry_index,
   input  logic [31:0]           req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [22:0]           rsp_block_number,
   output logic [4:0]            rsp_slot,
   output logic                  rsp_load_needed,
   output logic [31:0]           rsp_file_offset,
   output logic [17:0]           rsp_read_length,
   output logic                  rsp_stored_raw,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csl_cmd_type  cmd;
   csl_stat_type stat;

   csl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   csl_dp #(
      .INDEX_DEPTH (INDEX_DEPTH),
      .MAX_BURST   (MAX_BURST)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_lba          (req_lba),
      .req_count        (req_count),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_block_number (rsp_block_number),
      .rsp_slot         (rsp_slot),
      .rsp_load_needed  (rsp_load_needed),
      .rsp_file_offset  (rsp_file_offset),
      .rsp_read_length  (rsp_read_length),
      .rsp_stored_raw   (rsp_stored_raw),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result offered while input side is open");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("not idle after final item of a request");

   a_busy_after_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> req_stall)
      else $error("request dropped before its final item");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> rsp_last)
      else $error("error item without last marker");

endmodule

FILE: hw/rtl/csl_ctrl.sv
// Controller state machine of the sector locator.
module csl_ctrl import csl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_type,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output csl_cmd_type  cmd,
   input  csl_stat_type stat
);

   csl_state_type state_ff, state_in;
   logic          finish_ff, finish_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         finish_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_type == REQ_READ) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.range_bad || !stat.zso) state_in = S_EMIT;
            else                             state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.hit || stat.beyond) state_in = S_EMIT;
            else                         state_in = S_RD;
         end
         S_RD:    state_in = S_SHIFT;
         S_SHIFT: state_in = S_EVAL;
         S_EVAL:  state_in = S_CLAMP;
         S_CLAMP: state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_stall) state_in = finish_ff ? S_IDLE : S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = RES_RANGE;
      finish_in = finish_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_READ) cmd.take  = 1'b1;
               else                      cmd.write = 1'b1;
            end
         end
         S_DECIDE: begin
            if (stat.range_bad) begin
               cmd.out_load = 1'b1;
               cmd.kind     = RES_RANGE;
               finish_in    = 1'b1;
            end else if (!stat.zso) begin
               cmd.out_load = 1'b1;
               cmd.kind     = RES_ISO;
               finish_in    = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         S_DIV: begin
            if (!stat.div_done) cmd.div_step = 1'b1;
         end
         S_CHECK: begin
            if (stat.hit) begin
               cmd.out_load = 1'b1;
               cmd.kind     = RES_HIT;
               finish_in    = stat.last;
            end else if (stat.beyond) begin
               cmd.out_load = 1'b1;
               cmd.kind     = RES_BEYOND;
               finish_in    = 1'b1;
            end else begin
               cmd.rd_lo = 1'b1;
            end
         end
         S_RD:    cmd.rd_hi = 1'b1;
         S_SHIFT: cmd.shift = 1'b1;
         S_EVAL:  cmd.eval  = 1'b1;
         S_CLAMP: begin
            cmd.out_load = 1'b1;
            if (stat.corrupt) begin
               cmd.kind  = RES_CORRUPT;
               finish_in = 1'b1;
            end else begin
               cmd.kind  = RES_LOAD;
               finish_in = stat.last;
            end
         end
         S_EMIT: begin
            // advance to the next sector once this item is taken
            if (!rsp_stall && !finish_ff) cmd.sec_next = 1'b1;
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);

endmodule

FILE: hw/rtl/csl_dp.sv
// Datapath of the sector locator: settings, index memory, divider, offsets.
module csl_dp import csl_pkg::*; #(
   parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
   parameter int MAX_BURST   = MAX_BURST_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csl_cmd_type           cmd,
   output csl_stat_type          stat,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [22:0]           req_lba,
   input  logic [6:0]            req_count,
   input  logic [11:0]           req_entry_index,
   input  logic [31:0]           req_entry_value,
   output logic [22:0]           rsp_block_number,
   output logic [4:0]            rsp_slot,
   output logic                  rsp_load_needed,
   output logic [31:0]           rsp_file_offset,
   output logic [17:0]           rsp_read_length,
   output logic                  rsp_stored_raw,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   localparam int AW = $clog2(INDEX_DEPTH);

   logic        zso_ff;
   logic [23:0] total_ff;
   logic [5:0]  spb_ff;
   logic [11:0] bcount_ff;
   logic [4:0]  ashift_ff;
   logic [31:0] fsize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zso_ff    <= 1'b0;
         total_ff  <= '0;
         spb_ff    <= 6'd1;
         bcount_ff <= '0;
         ashift_ff <= '0;
         fsize_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ZSO_MODE:      zso_ff    <= csr_wdata[0];
            CSR_TOTAL_SECTORS: total_ff  <= csr_wdata[23:0];
            CSR_SECTORS_PER_B: spb_ff    <= csr_wdata[5:0];
            CSR_BLOCK_COUNT:   bcount_ff <= csr_wdata[11:0];
            CSR_ALIGN_SHIFT:   ashift_ff <= csr_wdata[4:0];
            CSR_FILE_SIZE:     fsize_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp block size to 1..32 sectors
   logic [5:0]  spb_eff;
   logic [16:0] bsize;
   logic [24:0] bsize_x257;
   logic [17:0] worst;

   always_comb begin
      if (spb_ff == 6'd0)                  spb_eff = 6'd1;
      else if (spb_ff > 6'(MAX_SPB))      spb_eff = 6'(MAX_SPB);
      else                                 spb_eff = spb_ff;
   end

   // bsize / 255 as bsize * 257 >> 16; exact since bsize is never a multiple of 255
   assign bsize      = {spb_eff, 11'b0};
   assign bsize_x257 = 25'(bsize) * 25'd257;
   assign worst      = 18'(bsize) + 18'(bsize_x257[24:16]) + 18'd64;

   // request registers
   logic [22:0] lba_ff;
   logic [6:0]  count_ff;
   logic [6:0]  left_ff;
   logic        range_bad_ff;
   logic        range_bad;

   assign range_bad = (req_count == 7'd0) || (req_count > 7'(MAX_BURST)) ||
                      (({1'b0, req_lba} + 24'(req_count)) > total_ff);

   // bit-serial divider; quotient becomes the block, remainder the slot
   logic [22:0] quo_ff;
   logic [5:0]  rem_ff;
   logic [4:0]  cnt_ff;
   logic [6:0]  trial;
   logic        trial_ge;

   assign trial    = {rem_ff, quo_ff[22]};
   assign trial_ge = (trial >= {1'b0, spb_eff});

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         lba_ff       <= req_lba;
         count_ff     <= req_count;
         left_ff      <= req_count - 7'd1;
         range_bad_ff <= range_bad;
      end else if (cmd.sec_next) begin
         left_ff <= left_ff - 7'd1;
      end

      if (cmd.div_start) begin
         quo_ff <= lba_ff;
         rem_ff <= '0;
         cnt_ff <= 5'd23;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? 6'(trial - {1'b0, spb_eff}) : trial[5:0];
         quo_ff <= {quo_ff[21:0], trial_ge};
         cnt_ff <= cnt_ff - 5'd1;
      end else if (cmd.sec_next) begin
         if (({1'b0, rem_ff} + 7'd1) == {1'b0, spb_eff}) begin
            rem_ff <= '0;
            quo_ff <= quo_ff + 23'd1;
         end else begin
            rem_ff <= rem_ff + 6'd1;
         end
      end
   end

   // current block
   logic        cur_valid_ff;
   logic [22:0] cur_blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_blk_ff   <= '0;
      end else if (cmd.write) begin
         cur_valid_ff <= 1'b0;
      end else if (cmd.out_load && cmd.kind == RES_LOAD) begin
         cur_valid_ff <= 1'b1;
         cur_blk_ff   <= quo_ff;
      end
   end

   // index memory, one port, registered read
   logic [31:0]   mem [INDEX_DEPTH];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   logic          wr_ok;

   assign wr_ok = ({5'b0, req_entry_index} < 17'(INDEX_DEPTH));
   assign waddr = AW'(req_entry_index);
   assign raddr = cmd.rd_hi ? AW'(quo_ff + 23'd1) : AW'(quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) mem[waddr] <= req_entry_value;
      if (cmd.rd_lo || cmd.rd_hi) rdata_ff <= mem[raddr];
   end

   // offsets and length
   logic [31:0] start_ff;
   logic [31:0] off_ff;
   logic [31:0] stop_ff;
   logic        raw_ff;
   logic        corrupt_ff;
   logic [17:0] want_ff;
   logic [31:0] diff;
   logic [31:0] avail;
   logic [17:0] len;

   assign diff  = stop_ff - off_ff;
   assign avail = fsize_ff - off_ff;
   assign len   = (32'(want_ff) > avail) ? avail[17:0] : want_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_hi) start_ff <= rdata_ff;
      if (cmd.shift) begin
         off_ff  <= {1'b0, start_ff[30:0]} << ashift_ff;
         stop_ff <= {1'b0, rdata_ff[30:0]} << ashift_ff;
         raw_ff  <= start_ff[31];
      end
      if (cmd.eval) begin
         corrupt_ff <= (stop_ff <= off_ff) || (off_ff >= fsize_ff);
         want_ff    <= (diff > 32'(worst)) ? worst : diff[17:0];
      end
   end

   // result register
   logic [22:0]    out_blk_ff;
   logic [4:0]     out_slot_ff;
   logic           out_load_ff;
   logic [31:0]    out_off_ff;
   logic [17:0]    out_len_ff;
   logic           out_raw_ff;
   csl_status_type out_status_ff;
   logic           out_last_ff;
   logic           is_last;

   assign is_last = (left_ff == 7'd0);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_blk_ff    <= quo_ff;
         out_slot_ff   <= rem_ff[4:0];
         out_load_ff   <= 1'b1;
         out_off_ff    <= '0;
         out_len_ff    <= '0;
         out_raw_ff    <= 1'b0;
         out_status_ff <= STAT_OK;
         out_last_ff   <= 1'b1;
         case (cmd.kind)
            RES_RANGE: begin
               out_blk_ff    <= '0;
               out_slot_ff   <= '0;
               out_load_ff   <= 1'b0;
               out_status_ff <= STAT_RANGE;
            end
            RES_ISO: begin
               out_blk_ff  <= lba_ff;
               out_slot_ff <= '0;
               out_load_ff <= 1'b0;
               out_off_ff  <= {lba_ff[20:0], 11'b0};
               out_len_ff  <= {count_ff, 11'b0};
               out_raw_ff  <= 1'b1;
            end
            RES_HIT: begin
               out_load_ff <= 1'b0;
               out_last_ff <= is_last;
            end
            RES_BEYOND:  out_status_ff <= STAT_BEYOND;
            RES_CORRUPT: out_status_ff <= STAT_CORRUPT;
            RES_LOAD: begin
               out_off_ff  <= off_ff;
               out_len_ff  <= len;
               out_raw_ff  <= raw_ff;
               out_last_ff <= is_last;
            end
            default: ;
         endcase
      end
   end

   assign rsp_block_number = out_blk_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_load_needed  = out_load_ff;
   assign rsp_file_offset  = out_off_ff;
   assign rsp_read_length  = out_len_ff;
   assign rsp_stored_raw   = out_raw_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_last         = out_last_ff;

   assign stat.range_bad = range_bad_ff;
   assign stat.zso       = zso_ff;
   assign stat.div_done  = (cnt_ff == 5'd0);
   assign stat.hit       = cur_valid_ff && (cur_blk_ff == quo_ff);
   assign stat.beyond    = ({1'b0, quo_ff} >= 24'(bcount_ff)) ||
                           (({1'b0, quo_ff} + 24'd1) >= 24'(INDEX_DEPTH));
   assign stat.corrupt   = corrupt_ff;
   assign stat.last      = is_last;

endmodule
